[rtl/tfsc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the readout stream checker.
package tfsc_pkg;

	// Stream markers and header word pattern
	localparam logic [31:0] START_WORD  = 32'hFFFF_FFFF;
	localparam logic [31:0] END_WORD    = 32'hE000_0000;
	localparam logic [7:0]  MODHDR_TAG  = 8'hF1;
	localparam logic [15:0] MODHDR_LOW  = 16'hFFFF;
	localparam logic [3:0]  NIB_HEADER  = 4'hF;
	localparam logic [3:0]  NIB_CHANNEL = 4'h1;
	localparam logic [3:0]  NIB_ROI_END = 4'h3;
	localparam logic [1:0]  TOP2_ROI_START = 2'b01;

	// Header phases, counted after the increment
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_FIRST  = 4'd1;
	localparam logic [3:0] PH_WCOUNT = 4'd3;
	localparam logic [3:0] PH_FRAME  = 4'd5;
	localparam logic [3:0] PH_CSUM   = 4'd6;
	localparam logic [3:0] PH_DONE   = 4'd7;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULE_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_CHANNEL = 1'b1;
	localparam logic [4:0] RST_MODULE_BASE  = 5'd3;
	localparam logic [5:0] RST_LAST_CHANNEL = 6'd63;

	// Decoupling queue
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// Output beat widths
	localparam int TDATA_W = 64;
	localparam int TUSER_W = 5;

	typedef enum logic [1:0] {
		HK_SAMPLE,
		HK_CHANNEL,
		HK_ROI_START,
		HK_ROI_END
	} half_kind_t;

	// One classified stream word
	typedef struct packed {
		logic        is_start;
		logic        is_end;
		logic        is_modhdr;
		logic        hdr_ok;
		logic [23:0] hdr_value;
		logic [4:0]  fem;
		logic [15:0] lo;
		logic [15:0] hi;
		half_kind_t  kind_lo;
		half_kind_t  kind_hi;
	} tfsc_item_t;

	// Effect of one data half
	typedef struct packed {
		logic signed [6:0] prior;
		logic              in_roi;
		logic [6:0]        ch_miss;
		logic              rs;
		logic              re;
	} half_res_t;

endpackage

[rtl/tfsc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts stream beats and classifies each word for the back end.
module tfsc_front import tfsc_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	output logic        push_valid,
	input  logic        push_ready,
	output tfsc_item_t  push_item
);

	function automatic half_kind_t classify_half(input logic [15:0] h);
		half_kind_t k;
		priority if (h[15:12] == NIB_CHANNEL)      k = HK_CHANNEL;
		else if (h[15:14] == TOP2_ROI_START)       k = HK_ROI_START;
		else if (h[15:12] == NIB_ROI_END)          k = HK_ROI_END;
		else                                       k = HK_SAMPLE;
		return k;
	endfunction

	logic [15:0] lo;
	logic [15:0] hi;

	assign lo = s_tdata[15:0];
	assign hi = s_tdata[31:16];

	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;

	always_comb begin
		push_item.is_start  = (s_tdata == START_WORD);
		push_item.is_end    = (s_tdata == END_WORD);
		push_item.is_modhdr = (hi[15:8] == MODHDR_TAG) && (lo == MODHDR_LOW);
		push_item.hdr_ok    = (hi[15:12] == NIB_HEADER) && (lo[15:12] == NIB_HEADER);
		push_item.hdr_value = {lo[11:0], hi[11:0]};
		push_item.fem       = hi[4:0];
		push_item.lo        = lo;
		push_item.hi        = hi;
		push_item.kind_lo   = classify_half(lo);
		push_item.kind_hi   = classify_half(hi);
	end

endmodule

[rtl/tfsc_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified words between front end and back end.
module tfsc_queue import tfsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  tfsc_item_t in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output tfsc_item_t out_item
);

	tfsc_item_t           mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;
	logic                 push;
	logic                 pop;

	assign in_ready  = (count_q != (Q_PTR_W+1)'(Q_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/tfsc_back.sv]
`timescale 1ns / 1ps
// Back end: frame and module tracking state, error increments and output register.
module tfsc_back import tfsc_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  tfsc_item_t            pop_item,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,
	output logic [TUSER_W-1:0]    m_tuser
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	function automatic half_res_t do_half(input half_kind_t kind, input logic [5:0] ch,
			input logic signed [6:0] prior, input logic in_roi, input logic gate);
		half_res_t         r;
		logic signed [7:0] diff;
		r.prior   = prior;
		r.in_roi  = in_roi;
		r.ch_miss = '0;
		r.rs      = 1'b0;
		r.re      = 1'b0;
		diff = $signed({2'b00, ch}) - $signed({prior[6], prior});
		unique case (kind)
			HK_CHANNEL: begin
				if (diff > 8'sd1 && gate) begin
					r.ch_miss = 7'(diff - 8'sd1);
				end
				r.prior  = $signed({1'b0, ch});
				r.in_roi = 1'b0;
			end
			HK_ROI_START: begin
				if (in_roi && gate) begin
					r.re = 1'b1;
				end
				r.in_roi = 1'b1;
			end
			HK_ROI_END: begin
				if (!in_roi && gate) begin
					r.rs = 1'b1;
				end
				r.in_roi = 1'b0;
			end
			HK_SAMPLE: begin
			end
		endcase
		return r;
	endfunction

	// Configuration
	logic [4:0] base_q;
	logic [5:0] last_ch_q;

	// Tracking state
	logic              in_frame_q, n_in_frame;
	logic [3:0]        phase_q, n_phase;
	logic              seeking_q, n_seeking;
	logic              in_hdr_q, n_in_hdr;
	logic [4:0]        slot_q, n_slot;
	logic              slot_ok_q, n_slot_ok;
	logic signed [6:0] prior_q, n_prior;
	logic              in_roi_q, n_in_roi;
	logic [31:0]       rwc_q, n_rwc;
	logic [31:0]       rsum_q, n_rsum;
	logic [23:0]       exp_wc_q, n_exp_wc;
	logic [23:0]       exp_sum_q, n_exp_sum;
	logic [23:0]       frame_q, n_frame;

	// Last frame seen per slot; an entry that is not valid reads as minus one
	logic [NUM_SLOTS-1:0] lf_valid_q;
	logic [23:0]          lf_frame_q [NUM_SLOTS];
	logic                 lf_we;
	logic [IDX_W-1:0]     lf_idx;
	logic [23:0]          lf_rd;
	logic                 lf_rd_valid;

	// Result of the current word
	logic        fe_miss, hdr_miss, wc_err, cs_err;
	logic [23:0] fr_miss;
	logic [6:0]  ch_miss;
	logic [1:0]  rs_miss, re_miss;

	// Output register
	logic               m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;
	logic [TUSER_W-1:0] m_tuser_q;

	logic        take;
	logic        gate1;
	logic        hdr_now;
	logic [3:0]  ph;
	logic [3:0]  ph_n;
	logic [4:0]  fem_off;
	logic signed [7:0] tail;
	logic [23:0] fr_diff;
	half_res_t   res_lo;
	half_res_t   res_hi;

	assign pop_ready   = !m_tvalid_q || m_tready;
	assign take        = pop_valid && pop_ready;
	assign lf_idx      = slot_q[IDX_W-1:0];
	assign lf_rd       = lf_frame_q[lf_idx];
	assign lf_rd_valid = lf_valid_q[lf_idx];
	assign gate1       = (frame_q > 24'd1);
	assign fem_off     = pop_item.fem - base_q;
	assign tail        = $signed({2'b00, last_ch_q}) - $signed({prior_q[6], prior_q});
	assign fr_diff     = n_frame - lf_rd;

	always_comb begin
		n_in_frame = in_frame_q;
		n_phase    = phase_q;
		n_seeking  = seeking_q;
		n_in_hdr   = in_hdr_q;
		n_slot     = slot_q;
		n_slot_ok  = slot_ok_q;
		n_prior    = prior_q;
		n_in_roi   = in_roi_q;
		n_rwc      = rwc_q;
		n_rsum     = rsum_q;
		n_exp_wc   = exp_wc_q;
		n_exp_sum  = exp_sum_q;
		n_frame    = frame_q;
		fe_miss    = 1'b0;
		hdr_miss   = 1'b0;
		fr_miss    = '0;
		ch_miss    = '0;
		rs_miss    = '0;
		re_miss    = '0;
		wc_err     = 1'b0;
		cs_err     = 1'b0;
		lf_we      = 1'b0;
		hdr_now    = in_hdr_q;
		ph         = phase_q;
		ph_n       = phase_q;
		res_lo     = do_half(pop_item.kind_lo, pop_item.lo[5:0], prior_q, in_roi_q, gate1);
		res_hi     = do_half(pop_item.kind_hi, pop_item.hi[5:0], res_lo.prior,
			res_lo.in_roi, gate1);

		priority if (pop_item.is_start) begin
			n_phase    = PH_FIRST;
			n_seeking  = 1'b1;
			fe_miss    = in_frame_q && (frame_q != '0);
			n_in_frame = 1'b1;
		end else if (pop_item.is_end) begin
			n_in_hdr   = 1'b0;
			n_in_frame = 1'b0;
		end else if (in_frame_q) begin
			if (seeking_q && pop_item.is_modhdr) begin
				hdr_now  = 1'b1;
				n_in_hdr = 1'b1;
				if (prior_q != -7'sd1 && tail > 8'sd0) begin
					ch_miss = tail[6:0];
				end
				n_prior   = -7'sd1;
				wc_err    = gate1 && !rwc_q[31] && (rwc_q != {8'd0, exp_wc_q});
				cs_err    = gate1 && !rsum_q[31] && (rsum_q > {8'd0, exp_sum_q});
				n_slot    = fem_off;
				n_slot_ok = (pop_item.fem >= base_q) &&
					({1'b0, fem_off} < 6'(NUM_SLOTS));
				ph        = PH_FIRST;
				n_seeking = 1'b0;
			end
			if (hdr_now) begin
				hdr_miss = (ph != PH_IDLE) && !pop_item.hdr_ok;
				ph_n     = ph + 4'd1;
				if (ph_n == PH_WCOUNT) begin
					n_exp_wc = pop_item.hdr_value;
					n_rwc    = '0;
				end else if (ph_n == PH_FRAME) begin
					n_frame = pop_item.hdr_value;
					if (slot_ok_q) begin
						lf_we = 1'b1;
						if (!lf_rd_valid) begin
							if (n_frame != 24'd0 && n_frame != 24'd3) begin
								fr_miss = n_frame;
							end
						end else if (n_frame > lf_rd && fr_diff != 24'd1 && fr_diff != 24'd4) begin
							fr_miss = fr_diff - 24'd1;
						end
					end
				end else if (ph_n == PH_CSUM) begin
					n_exp_sum = pop_item.hdr_value;
					n_rsum    = '0;
				end else if (ph_n == PH_DONE) begin
					ph_n      = PH_IDLE;
					n_in_hdr  = 1'b0;
					n_seeking = 1'b1;
				end
				n_phase = ph_n;
			end else begin
				n_rsum   = rsum_q + {16'd0, pop_item.lo} + {16'd0, pop_item.hi};
				n_rwc    = rwc_q + 32'd2;
				n_prior  = res_hi.prior;
				n_in_roi = res_hi.in_roi;
				ch_miss  = res_lo.ch_miss + res_hi.ch_miss;
				rs_miss  = {1'b0, res_lo.rs} + {1'b0, res_hi.rs};
				re_miss  = {1'b0, res_lo.re} + {1'b0, res_hi.re};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= RST_MODULE_BASE;
			last_ch_q <= RST_LAST_CHANNEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODULE_BASE:  base_q    <= cfg_data[4:0];
				CFG_LAST_CHANNEL: last_ch_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			phase_q    <= PH_IDLE;
			seeking_q  <= 1'b0;
			in_hdr_q   <= 1'b0;
			slot_q     <= '0;
			slot_ok_q  <= 1'b0;
			prior_q    <= -7'sd1;
			in_roi_q   <= 1'b0;
			rwc_q      <= '1;
			rsum_q     <= '1;
			exp_wc_q   <= '0;
			exp_sum_q  <= '0;
			frame_q    <= '0;
			lf_valid_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (take) begin
				in_frame_q <= n_in_frame;
				phase_q    <= n_phase;
				seeking_q  <= n_seeking;
				in_hdr_q   <= n_in_hdr;
				slot_q     <= n_slot;
				slot_ok_q  <= n_slot_ok;
				prior_q    <= n_prior;
				in_roi_q   <= n_in_roi;
				rwc_q      <= n_rwc;
				rsum_q     <= n_rsum;
				exp_wc_q   <= n_exp_wc;
				exp_sum_q  <= n_exp_sum;
				frame_q    <= n_frame;
				if (lf_we) begin
					lf_valid_q[lf_idx] <= 1'b1;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			if (lf_we) begin
				lf_frame_q[lf_idx] <= n_frame;
			end
			m_tdata_q <= {1'b0, cs_err, wc_err, re_miss, rs_miss, ch_miss, fr_miss,
				hdr_miss, fe_miss, n_frame};
			m_tuser_q <= {slot_ok_q, slot_q[3:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[rtl/tpc_fem_stream_checker_core.sv]
`timescale 1ns / 1ps
// Top level of the front-end readout stream checker.
//
// Checks a front-end readout stream one 32-bit word per beat and returns one result beat
// per input beat, in order. The word 0xFFFFFFFF opens a frame and 0xE0000000 closes it;
// inside a frame a module header word (high half 0xF1xx, low half 0xFFFF) starts a
// six-word header carrying the word count, the frame number and the checksum, and all
// other words are two 16-bit data halves (low half first) that mark channel starts, ROI
// starts and ROI ends. Each result carries the error increments caused by its word and
// the module slot they belong to (the previous module on a module header word). The
// block sustains one word per clock while the output is not stalled: the front end
// classifies each accepted word and pushes it into a four-entry queue, and the back end
// updates all tracking state for one word per cycle and loads the output register. A
// stalled output fills the queue before s_tready drops. No clearing pass follows reset.
// Configuration registers (0: module number mapped to slot zero, 1: last expected
// channel) are written through cfg_we with cfg_index and cfg_data; the user must write
// them only while no beats are in flight, which the block itself does not enforce.
module tpc_fem_stream_checker_core import tfsc_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [31:0] data_word
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [23:0] frame_number, [24] frame_end_missing, [25] header_word_missing,
	// [49:26] frames_missed, [56:50] channels_missed, [58:57] roi_starts_missed,
	// [60:59] roi_ends_missed, [61] word_count_error, [62] checksum_error, [63] zero
	output logic [TDATA_W-1:0]    m_tdata,
	output logic [TUSER_W-1:0]    m_tuser    // [3:0] module_slot, [4] slot_valid
);

	logic       push_valid;
	logic       push_ready;
	tfsc_item_t push_item;
	logic       q_valid;
	logic       q_ready;
	tfsc_item_t q_item;

	// Classify each beat as it is accepted
	tfsc_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Decouple the front end from result back-pressure
	tfsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_item   (push_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	// Advance the tracking state and register the result beat
	tfsc_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_item  (q_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// A valid slot always lies inside the slot range
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> 32'(m_tuser[3:0]) < NUM_SLOTS)
		else $error("slot_valid set for a slot outside the range");

	// Skipped frames are only counted for a module with a valid slot
	a_frames_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[49:26] != 24'd0) |-> m_tuser[4])
		else $error("frames_missed reported without a valid slot");

	// ROI, word count and checksum errors need a frame number above one
	a_frame_gate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[62:57] != 6'd0) |-> m_tdata[23:0] > 24'd1)
		else $error("gated error reported with frame number of one or less");

	// Input back-pressure only comes from a full queue
	a_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_valid)
		else $error("input stalled while the queue is empty");

endmodule
